/* sv/sfcc_pkg.sv */
// Shared types, codes and the CRC-8 step for the sensor frame CRC checker.
`default_nettype none
package sfcc_pkg;

  // Command kinds carried on the input side band
  typedef enum logic [1:0] {
    CMD_BYTE      = 2'd0,
    CMD_BUS_FAIL  = 2'd1,
    CMD_MEAS_FAIL = 2'd2,
    CMD_REINIT_OK = 2'd3
  } cmd_t;

  // Result status codes carried on the output side band
  typedef enum logic [2:0] {
    ST_BYTE_TAKEN  = 3'd0,
    ST_NEW_SAMPLE  = 3'd1,
    ST_RETRY       = 3'd2,
    ST_MEAS_FAILED = 3'd3,
    ST_REINIT_ACK  = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic {
    REG_ERROR_LIMIT   = 1'b0,
    REG_READ_ATTEMPTS = 1'b1
  } reg_idx_t;

  // One classified word travelling from the front end to the back end
  typedef struct packed {
    cmd_t       command;
    logic [7:0] rx_byte;
  } item_t;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0]  CRC_POLY            = 8'h31;
  localparam logic [7:0]  CRC_INIT            = 8'hFF;
  localparam logic [15:0] ECO2_RESET          = 16'd400;
  localparam logic [3:0]  ERROR_LIMIT_RESET   = 4'd5;
  localparam logic [2:0]  READ_ATTEMPTS_RESET = 3'd3;
  localparam logic [3:0]  COUNT_MAX           = 4'd15;
  localparam logic [2:0]  POS_CRC_FIRST       = 3'd2;
  localparam logic [2:0]  POS_CRC_LAST        = 3'd5;

  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned OUT_DATA_W = 40;

  // Advance the CRC-8 (MSB first, no reflection) by one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/sfcc_front.sv */
// Front end: take input words, classify the command and register them.
`default_nettype none
module sfcc_front
  import sfcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0] s_tuser,   // [1:0] command
  output logic            q_valid,
  input  wire logic       q_ready,
  output item_t           q_item
);

  logic  valid;
  item_t item;

  // Accept whenever the stage is empty or draining this cycle
  assign s_tready = !valid || q_ready;
  assign q_valid  = valid;
  assign q_item   = item;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // Classify and capture the word; the byte only matters for reply bytes
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command <= cmd_t'(s_tuser);
      item.rx_byte <= (cmd_t'(s_tuser) == CMD_BYTE) ? s_tdata : 8'h00;
    end
  end

endmodule
`default_nettype wire

/* sv/sfcc_queue.sv */
// Short queue between the front end and the back end.
`default_nettype none
module sfcc_queue
  import sfcc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_FULL);
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* sv/sfcc_back.sv */
// Back end: frame tracking, CRC check, retry and error counting, result register.
`default_nettype none
module sfcc_back
  import sfcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire reg_idx_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire item_t                 q_item,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic [2:0]                 m_tuser
);

  // Configuration
  logic [3:0] error_limit;
  logic [2:0] read_attempts;

  // Frame and measurement state
  logic [2:0]  byte_position,      byte_position_next;
  logic [7:0]  crc_accumulator,    crc_accumulator_next;
  logic [15:0] first_word_buffer,  first_word_buffer_next;
  logic [15:0] second_word_buffer, second_word_buffer_next;
  logic        frame_bad,          frame_bad_next;
  logic [2:0]  attempts_used,      attempts_used_next;
  logic [3:0]  consecutive_errors, consecutive_errors_next;
  logic [15:0] held_eco2,          held_eco2_next;
  logic [15:0] held_tvoc,          held_tvoc_next;
  logic        has_sample,         has_sample_next;
  status_t     status_next;

  // Result register
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  status_t               out_status;

  logic       take;
  logic [2:0] attempt_inc;
  logic       attempt_over;
  logic [3:0] errors_bumped;

  assign q_ready  = !out_valid || m_tready;
  assign take     = q_valid && q_ready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_status;

  assign attempt_inc   = attempts_used + 3'd1;
  assign attempt_over  = (attempt_inc >= read_attempts);
  assign errors_bumped = (consecutive_errors == COUNT_MAX) ? consecutive_errors
                                                           : consecutive_errors + 4'd1;

  // Work out the state after this word
  always_comb begin
    byte_position_next      = byte_position;
    crc_accumulator_next    = crc_accumulator;
    first_word_buffer_next  = first_word_buffer;
    second_word_buffer_next = second_word_buffer;
    frame_bad_next          = frame_bad;
    attempts_used_next      = attempts_used;
    consecutive_errors_next = consecutive_errors;
    held_eco2_next          = held_eco2;
    held_tvoc_next          = held_tvoc;
    has_sample_next         = has_sample;
    status_next             = ST_BYTE_TAKEN;
    unique case (q_item.command)
      CMD_BYTE: begin
        if (byte_position == POS_CRC_FIRST || byte_position == POS_CRC_LAST) begin
          // Check byte closes a word
          if (crc_accumulator != q_item.rx_byte) begin
            frame_bad_next = 1'b1;
          end
          crc_accumulator_next = CRC_INIT;
        end else begin
          crc_accumulator_next = crc8_byte(crc_accumulator, q_item.rx_byte);
          case (byte_position)
            3'd0:    first_word_buffer_next[15:8]  = q_item.rx_byte;
            3'd1:    first_word_buffer_next[7:0]   = q_item.rx_byte;
            3'd3:    second_word_buffer_next[15:8] = q_item.rx_byte;
            default: second_word_buffer_next[7:0]  = q_item.rx_byte;
          endcase
        end
        if (byte_position >= POS_CRC_LAST) begin
          // End of frame: latch the sample or count a failed attempt
          if (!frame_bad_next) begin
            held_eco2_next          = first_word_buffer;
            held_tvoc_next          = second_word_buffer;
            has_sample_next         = 1'b1;
            consecutive_errors_next = 4'd0;
            attempts_used_next      = 3'd0;
            status_next             = ST_NEW_SAMPLE;
          end else if (attempt_over) begin
            attempts_used_next      = 3'd0;
            consecutive_errors_next = errors_bumped;
            status_next             = ST_MEAS_FAILED;
          end else begin
            attempts_used_next = attempt_inc;
            status_next        = ST_RETRY;
          end
          byte_position_next   = 3'd0;
          crc_accumulator_next = CRC_INIT;
          frame_bad_next       = 1'b0;
        end else begin
          byte_position_next = byte_position + 3'd1;
        end
      end
      CMD_BUS_FAIL: begin
        // Drop the partial frame, count one failed attempt
        byte_position_next   = 3'd0;
        crc_accumulator_next = CRC_INIT;
        frame_bad_next       = 1'b0;
        if (attempt_over) begin
          attempts_used_next      = 3'd0;
          consecutive_errors_next = errors_bumped;
          status_next             = ST_MEAS_FAILED;
        end else begin
          attempts_used_next = attempt_inc;
          status_next        = ST_RETRY;
        end
      end
      CMD_MEAS_FAIL: begin
        // Fail the measurement at once
        byte_position_next      = 3'd0;
        crc_accumulator_next    = CRC_INIT;
        frame_bad_next          = 1'b0;
        attempts_used_next      = 3'd0;
        consecutive_errors_next = errors_bumped;
        status_next             = ST_MEAS_FAILED;
      end
      CMD_REINIT_OK: begin
        // Clear the frame, the attempt count and the error count; keep the held sample
        byte_position_next      = 3'd0;
        crc_accumulator_next    = CRC_INIT;
        frame_bad_next          = 1'b0;
        attempts_used_next      = 3'd0;
        consecutive_errors_next = 4'd0;
        status_next             = ST_REINIT_ACK;
      end
      default: begin
        status_next = ST_BYTE_TAKEN;
      end
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit   <= ERROR_LIMIT_RESET;
      read_attempts <= READ_ATTEMPTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ERROR_LIMIT:   error_limit   <= cfg_data[3:0];
        REG_READ_ATTEMPTS: read_attempts <= cfg_data[2:0];
        default:           error_limit   <= error_limit;
      endcase
    end
  end

  // Advance state on each word taken from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= 3'd0;
      crc_accumulator    <= CRC_INIT;
      first_word_buffer  <= 16'd0;
      second_word_buffer <= 16'd0;
      frame_bad          <= 1'b0;
      attempts_used      <= 3'd0;
      consecutive_errors <= 4'd0;
      held_eco2          <= ECO2_RESET;
      held_tvoc          <= 16'd0;
      has_sample         <= 1'b0;
    end else if (take) begin
      byte_position      <= byte_position_next;
      crc_accumulator    <= crc_accumulator_next;
      first_word_buffer  <= first_word_buffer_next;
      second_word_buffer <= second_word_buffer_next;
      frame_bad          <= frame_bad_next;
      attempts_used      <= attempts_used_next;
      consecutive_errors <= consecutive_errors_next;
      held_eco2          <= held_eco2_next;
      held_tvoc          <= held_tvoc_next;
      has_sample         <= has_sample_next;
    end
  end

  // Hold the result valid until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ready) begin
      out_valid <= q_valid;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (take) begin
      out_status <= status_next;
      out_data   <= {2'b00,
                     consecutive_errors_next,
                     has_sample_next,
                     held_tvoc_next,
                     held_eco2_next,
                     (consecutive_errors_next >= error_limit)};
    end
  end

endmodule
`default_nettype wire

/* sv/sensor_frame_crc_checker_core.sv */
// Sensor frame CRC checker: top level joining front end, queue and back end.
//
// Usage: each input word carries a command on s_tuser and, for reply bytes,
// the received byte on s_tdata. Six reply bytes form a frame of two words,
// each two data bytes followed by a CRC-8 (poly 0x31, init 0xFF). Every input
// word produces exactly one result word: status on m_tuser, and on m_tdata the
// reinit request, both sample values, the sample-valid flag and the error count.
// An accepted word passes through the front-end register and the queue; its
// result is loaded into the result register that drives m_tvalid. Throughput
// is one word per cycle while the receiver keeps m_tready high; the CRC and
// state update in the back end is combinational. The user must write the
// error limit and the attempt limit through the cfg port only while the block
// is idle; the block does not enforce this. Reset (rst, synchronous) empties
// all stages, clears the frame and counters, loads the default limits and
// sets the held sample to 400 and 0. If the receiver stalls, the result register
// holds, the queue fills, then the front end drops s_tready; nothing is lost.
`default_nettype none
module sensor_frame_crc_checker_core
  import sfcc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,  // [7:0] rx_byte
  input  wire logic [1:0]            s_tuser,  // [1:0] command
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [0] reinit_request, [16:1] eco2_value, [32:17] tvoc_value,
  // [33] sample_valid, [37:34] error_count, [39:38] zero
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic [2:0]                 m_tuser   // [2:0] status
);

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  b_valid;
  logic  b_ready;
  item_t b_item;

  sfcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  sfcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  sfcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (reg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_item    (b_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

/* verif/sfcc_result_checker.sv */
// Result checker for the sensor frame CRC checker: predicts each result word and compares it.
`timescale 1ns / 100ps
module sfcc_result_checker
  import sfcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [7:0]            s_tdata,  // [7:0] rx_byte
  input  wire logic [1:0]            s_tuser,  // [1:0] command
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  // [0] reinit_request, [16:1] eco2_value, [32:17] tvoc_value,
  // [33] sample_valid, [37:34] error_count, [39:38] zero
  input  wire logic [OUT_DATA_W-1:0] m_tdata,
  input  wire logic [2:0]            m_tuser,  // [2:0] status
  output int unsigned                n_pending,
  output int unsigned                n_fail
);

  typedef struct {
    status_t     status;
    logic        reinit;
    logic [15:0] eco2;
    logic [15:0] tvoc;
    logic        valid;
    logic [3:0]  errs;
  } sensor_report_t;

  // Reports still owed by the block, oldest first
  sensor_report_t owed_reports[$];
  sensor_report_t oldest;

  // Limits as last written
  logic [3:0]  err_limit;
  logic [2:0]  att_limit;

  // Frame and measurement state
  logic [2:0]  frame_pos;
  logic [7:0]  frame_crc;
  logic [15:0] word_a;
  logic [15:0] word_b;
  logic        frame_broken;
  logic [2:0]  att_used;
  logic [3:0]  run_errors;
  logic [15:0] held_a;
  logic [15:0] held_b;
  logic        got_sample;
  int unsigned fails;

  // Advance the CRC-8 by one byte, most significant bit first
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  task automatic drop_frame();
    frame_pos    = 3'd0;
    frame_crc    = CRC_INIT;
    frame_broken = 1'b0;
  endtask

  task automatic bump_errors();
    if (run_errors != COUNT_MAX) begin
      run_errors = run_errors + 4'd1;
    end
  endtask

  // Count one failed read attempt and give the status it leads to
  task automatic fail_attempt(output status_t st);
    att_used = att_used + 3'd1;
    if (att_used >= att_limit) begin
      att_used = 3'd0;
      bump_errors();
      st = ST_MEAS_FAILED;
    end else begin
      st = ST_RETRY;
    end
  endtask

  // Work out the report for one accepted input word and queue it
  task automatic predict_report(input cmd_t cmd, input logic [7:0] rx);
    sensor_report_t rep;
    status_t st;
    st = ST_BYTE_TAKEN;
    case (cmd)
      CMD_BYTE: begin
        if (frame_pos == POS_CRC_FIRST || frame_pos == POS_CRC_LAST) begin
          if (frame_crc != rx) frame_broken = 1'b1;
          frame_crc = CRC_INIT;
        end else begin
          frame_crc = crc_step(frame_crc, rx);
          case (frame_pos)
            3'd0: word_a[15:8] = rx;
            3'd1: word_a[7:0]  = rx;
            3'd3: word_b[15:8] = rx;
            default: word_b[7:0] = rx;
          endcase
        end
        if (frame_pos >= POS_CRC_LAST) begin
          if (!frame_broken) begin
            held_a     = word_a;
            held_b     = word_b;
            got_sample = 1'b1;
            run_errors = 4'd0;
            att_used   = 3'd0;
            st         = ST_NEW_SAMPLE;
          end else begin
            fail_attempt(st);
          end
          drop_frame();
        end else begin
          frame_pos = frame_pos + 3'd1;
        end
      end
      CMD_BUS_FAIL: begin
        drop_frame();
        fail_attempt(st);
      end
      CMD_MEAS_FAIL: begin
        drop_frame();
        att_used = 3'd0;
        bump_errors();
        st = ST_MEAS_FAILED;
      end
      default: begin
        drop_frame();
        att_used   = 3'd0;
        run_errors = 4'd0;
        st         = ST_REINIT_ACK;
      end
    endcase
    rep.status = st;
    rep.reinit = (run_errors >= err_limit);
    rep.eco2   = held_a;
    rep.tvoc   = held_b;
    rep.valid  = got_sample;
    rep.errs   = run_errors;
    owed_reports.push_back(rep);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Track configuration, predict on input words, compare on output words
  always @(posedge clk) begin
    if (rst) begin
      err_limit  = ERROR_LIMIT_RESET;
      att_limit  = READ_ATTEMPTS_RESET;
      drop_frame();
      word_a     = 16'd0;
      word_b     = 16'd0;
      att_used   = 3'd0;
      run_errors = 4'd0;
      held_a     = ECO2_RESET;
      held_b     = 16'd0;
      got_sample = 1'b0;
      fails      = 0;
      owed_reports.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ERROR_LIMIT) begin
          err_limit = cfg_data[3:0];
        end else begin
          att_limit = cfg_data[2:0];
        end
      end
      if (s_tvalid && s_tready) begin
        predict_report(cmd_t'(s_tuser), s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (owed_reports.size() == 0) begin
          $error("result word with no expectation: status %0d, data %h", m_tuser, m_tdata);
          fails++;
        end else begin
          oldest = owed_reports.pop_front();
          check_field("status", 16'(oldest.status), 16'(m_tuser));
          check_field("reinit_request", 16'(oldest.reinit), 16'(m_tdata[0]));
          check_field("eco2_value", oldest.eco2, m_tdata[16:1]);
          check_field("tvoc_value", oldest.tvoc, m_tdata[32:17]);
          check_field("sample_valid", 16'(oldest.valid), 16'(m_tdata[33]));
          check_field("error_count", 16'(oldest.errs), 16'(m_tdata[37:34]));
        end
      end
    end
    n_pending <= owed_reports.size();
    n_fail    <= fails;
  end

endmodule

/* verif/tb_sensor_frame_crc_checker_core.sv */
// Testbench top for the sensor frame CRC checker: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_sensor_frame_crc_checker_core;
  import sfcc_pkg::*;

  localparam int unsigned TOTAL_WORDS = 1950;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_STALL  = 200;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = 8'd0;  // [7:0] rx_byte
  logic [1:0]            s_tuser   = 2'd0;  // [1:0] command
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // [0] reinit_request, [16:1] eco2_value, [32:17] tvoc_value,
  // [33] sample_valid, [37:34] error_count, [39:38] zero
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [2:0]            m_tuser;           // [2:0] status

  int unsigned n_pending;
  int unsigned n_fail;
  int unsigned words_sent = 0;
  int unsigned stall_asked = 0;
  int unsigned stall_done = 0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;

  sensor_frame_crc_checker_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  sfcc_result_checker u_report_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .n_pending (n_pending),
    .n_fail    (n_fail)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none at all in calm stretches
  function automatic int unsigned gap_len(input bit calm);
    int unsigned pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Offer one word, hold it until accepted, then possibly idle for a while
  task automatic send_word(input cmd_t cmd, input logic [7:0] rx);
    int unsigned n;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= rx;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    n = gap_len(src_calm);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Send a reply frame, optionally with one byte spoilt, optionally cut
  // short after some bytes and followed by a failure command
  task automatic send_frame(input logic [15:0] first_w, input logic [15:0] second_w,
                            input bit damage, input int unsigned cut, input cmd_t tail);
    logic [7:0] frame_bytes [6];
    int unsigned k;
    frame_bytes[0] = first_w[15:8];
    frame_bytes[1] = first_w[7:0];
    frame_bytes[2] = crc8_byte(crc8_byte(CRC_INIT, frame_bytes[0]), frame_bytes[1]);
    frame_bytes[3] = second_w[15:8];
    frame_bytes[4] = second_w[7:0];
    frame_bytes[5] = crc8_byte(crc8_byte(CRC_INIT, frame_bytes[3]), frame_bytes[4]);
    if (damage) begin
      k = $urandom_range(0, 5);
      frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < 6 && i < cut; i++) begin
      send_word(CMD_BYTE, frame_bytes[i]);
    end
    if (cut < 6) begin
      send_word(tail, 8'($urandom));
    end
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering and wait until every result word has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mix of good frames with random content, broken frames and failures
  task automatic random_traffic(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(rand_word(), rand_word(), 1'b0, 6, CMD_BYTE);
      end else if (pick < 67) begin
        send_frame(rand_word(), rand_word(), 1'b1, 6, CMD_BYTE);
      end else if (pick < 77) begin
        send_frame(rand_word(), rand_word(), 1'b0, $urandom_range(0, 5), CMD_BUS_FAIL);
      end else if (pick < 82) begin
        send_frame(rand_word(), rand_word(), 1'b0, $urandom_range(0, 5), CMD_MEAS_FAIL);
      end else if (pick < 87) begin
        // run of failed measurements, long enough at times to saturate
        n = $urandom_range(1, 20);
        repeat (n) send_word(CMD_MEAS_FAIL, 8'($urandom));
      end else if (pick < 90) begin
        send_word(CMD_REINIT_OK, 8'($urandom));
      end else begin
        // stray bytes that knock the frame out of step
        n = $urandom_range(1, 3);
        repeat (n) send_word(CMD_BYTE, 8'($urandom));
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int unsigned n_off;
    int unsigned n_on;
    do @(posedge clk); while (rst);
    forever begin
      if (stall_asked != stall_done) begin
        n_off = LONG_STALL;
        stall_done = stall_asked;
      end else begin
        n_off = gap_len(sink_calm);
      end
      if (n_off > 0) begin
        m_tready <= 1'b0;
        repeat (n_off) @(posedge clk);
      end
      m_tready <= 1'b1;
      n_on = $urandom_range(1, 8);
      repeat (n_on) @(posedge clk);
    end
  end

  // Watchdog on the whole run
  initial begin
    for (int unsigned c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [3:0] lim;
    logic [2:0] att;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: held values before a sample, extreme words, bad CRC,
    // bus failure and measure failure mid-frame, reinit
    send_word(CMD_MEAS_FAIL, 8'h00);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 6, CMD_BYTE);
    send_frame(16'h1234, 16'hABCD, 1'b1, 6, CMD_BYTE);
    send_frame(16'h8001, 16'h7FFE, 1'b0, 2, CMD_BUS_FAIL);
    send_frame(16'h5A5A, 16'hA5A5, 1'b0, 1, CMD_MEAS_FAIL);
    send_word(CMD_REINIT_OK, 8'hFF);
    send_frame(16'h0000, 16'hFFFF, 1'b0, 6, CMD_BYTE);

    // Random phases, each under its own limits
    for (int unsigned phase = 0; words_sent < TOTAL_WORDS; phase++) begin
      wait_drained();
      case (phase)
        0: begin lim = 4'd15; att = 3'd7; end
        1: begin lim = 4'd1;  att = 3'd1; end
        2: begin lim = 4'd0;  att = 3'd0; end
        default: begin
          lim = 4'($urandom_range(1, 15));
          att = 3'($urandom_range(1, 7));
        end
      endcase
      cfg_write(REG_ERROR_LIMIT, lim);
      cfg_write(REG_READ_ATTEMPTS, {1'($urandom), att});
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      if (phase % 5 == 1) begin
        // keep offering words while the receiver holds off
        src_calm = 1'b1;
        stall_asked++;
      end
      random_traffic($urandom_range(80, 160));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
